### hw/rtl/iaie_pkg.sv
// Shared types and constants for the indexed array insert/erase core.
`default_nettype none
package iaie_pkg;

  localparam int unsigned DefCapacity    = 256;
  localparam int unsigned DefElementBits = 32;

  // Read-out tree: cells are grouped, one group entry selected per cycle.
  localparam int unsigned GroupBits = 4;
  localparam int unsigned GroupSize = 1 << GroupBits;

  // Port widths fixed by the request and result words.
  localparam int unsigned OpW     = 4;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 9;

  typedef enum logic [OpW-1:0] {
    OP_READ   = 4'd0,
    OP_WRITE  = 4'd1,
    OP_INSERT = 4'd2,
    OP_ERASE  = 4'd3,
    OP_PUSH   = 4'd4,
    OP_POP    = 4'd5,
    OP_CLEAR  = 4'd6,
    OP_FRONT  = 4'd7,
    OP_BACK   = 4'd8
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'b001,
    FSM_GROUP = 3'b010,
    FSM_FINAL = 3'b100
  } fsm_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic en;
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/iaie_cell.sv
// One storage cell of the row: holds an element, loads it or takes a neighbor's.
`default_nettype none
module iaie_cell
  import iaie_pkg::*;
#(
  parameter int unsigned ELEMENT_BITS = DefElementBits,
  parameter int unsigned ADDR_W       = 8,
  parameter int unsigned CELL_IDX     = 0
) (
  input  wire logic                    clk_i,
  input  wire cell_cmd_t               cmd_i,
  input  wire logic [ADDR_W-1:0]       idx_i,
  input  wire logic [ELEMENT_BITS-1:0] value_i,
  input  wire logic [ELEMENT_BITS-1:0] left_i,
  input  wire logic [ELEMENT_BITS-1:0] right_i,
  output      logic [ELEMENT_BITS-1:0] data_o
);

  localparam logic [ADDR_W-1:0] MyIdx = ADDR_W'(CELL_IDX);

  logic [ELEMENT_BITS-1:0] data_q, data_d;
  logic                    upd;

  always_comb begin
    upd    = 1'b0;
    data_d = data_q;
    if (cmd_i.en) begin
      if (cmd_i.load && idx_i == MyIdx) begin
        upd    = 1'b1;
        data_d = value_i;
      end else if (cmd_i.shift_up && MyIdx > idx_i) begin
        upd    = 1'b1;
        data_d = left_i;
      end else if (cmd_i.shift_down && MyIdx >= idx_i) begin
        upd    = 1'b1;
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

### hw/rtl/iaie_rdtree.sv
// Two-level read-out tree over the cell row: registered group select, then final select.
`default_nettype none
module iaie_rdtree
  import iaie_pkg::*;
#(
  parameter int unsigned ELEMENT_BITS = DefElementBits,
  parameter int unsigned NUM_GROUPS   = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    grp_en_i,
  input  wire logic [ELEMENT_BITS-1:0] cells_i [NUM_GROUPS*GroupSize],
  input  wire logic [$clog2(NUM_GROUPS)+GroupBits-1:0] addr_i,
  output      logic [ELEMENT_BITS-1:0] data_o
);

  localparam int unsigned GW = $clog2(NUM_GROUPS);

  logic [ELEMENT_BITS-1:0] grp_q [NUM_GROUPS];
  logic [GroupBits-1:0]    lo;
  logic [GW-1:0]           hi;

  assign lo = addr_i[GroupBits-1:0];
  assign hi = addr_i[GW+GroupBits-1:GroupBits];

  // Pick one entry in every group.
  always_ff @(posedge clk_i) begin
    if (grp_en_i) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_q[g] <= cells_i[g*GroupSize + int'(lo)];
      end
    end
  end

  assign data_o = grp_q[hi];

endmodule
`default_nettype wire

### hw/rtl/indexed_array_insert_erase_core.sv
// Top level of the indexed array core: request decode, cell row, read-out and result register.
// A request passes through the sequencer states accept, group select and result load; the
// core takes no new request until the last one is loaded, and a waiting result word holds
// the input off until it is taken.
// Insert and erase shift the cells at and above the index in the accept cycle itself.
// Reset clears the element count, the sequencer and the result valid; cell data is not reset.
`default_nettype none
module indexed_array_insert_erase_core
  import iaie_pkg::*;
#(
  parameter int unsigned CAPACITY     = DefCapacity,
  parameter int unsigned ELEMENT_BITS = DefElementBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [OpW-1:0]     operation_i,
  input  wire logic [IndexW-1:0]  index_i,
  input  wire logic [ValueW-1:0]  value_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [ValueW-1:0]  read_value_o,
  output      logic [StatusW-1:0] status_o,
  output      logic [CountW-1:0]  element_count_o
);

  // Widths: cell address, element count, compare width, read-out tree.
  localparam int unsigned AW      = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned XW      = (CNT_W > IndexW) ? CNT_W : IndexW;
  localparam int unsigned NG_RAW  = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam int unsigned NG      = (NG_RAW < 2) ? 2 : NG_RAW;
  localparam int unsigned RA_W    = $clog2(NG) + GroupBits;
  localparam int unsigned ROW_LEN = NG * GroupSize;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  fsm_e               state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;

  // Pending result, captured at accept.
  logic               rd_en_q;
  logic [RA_W-1:0]    rd_addr_q;
  status_e            pend_status_q;
  logic [CountW-1:0]  pend_count_q;

  // Result register.
  logic               out_valid_q;
  logic [ValueW-1:0]  out_value_q;
  status_e            out_status_q;
  logic [CountW-1:0]  out_count_q;

  logic in_accept;
  logic out_load;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Request decode against the current count
  // ---------------------------------------------------------------------------
  logic [XW-1:0]           fill_x, idx_x, cap_x, fill_m1;
  logic                    in_rng, full, empty;
  cell_cmd_t               cmd;
  logic [AW-1:0]           cmd_idx;
  logic                    rd_en_d;
  logic [RA_W-1:0]         rd_addr_d;
  status_e                 status_d;
  logic [ELEMENT_BITS-1:0] elem_value;

  assign fill_x  = XW'(fill_q);
  assign idx_x   = XW'(index_i);
  assign cap_x   = XW'(CAPACITY);
  assign fill_m1 = fill_x - XW'(1);
  assign in_rng  = idx_x < fill_x;
  assign full    = (fill_x == cap_x);
  assign empty   = (fill_q == '0);

  // Keep the element width of the incoming data.
  if (ELEMENT_BITS <= ValueW) begin : g_val_trunc
    assign elem_value = value_i[ELEMENT_BITS-1:0];
  end else begin : g_val_ext
    assign elem_value = ELEMENT_BITS'(value_i);
  end

  always_comb begin
    cmd       = '0;
    cmd_idx   = idx_x[AW-1:0];
    rd_en_d   = 1'b0;
    rd_addr_d = RA_W'(idx_x[AW-1:0]);
    status_d  = STAT_OK;
    fill_d    = fill_q;
    case (op_e'(operation_i))
      OP_READ: begin
        if (in_rng) rd_en_d = 1'b1;
        else        status_d = STAT_RANGE;
      end
      OP_WRITE: begin
        if (in_rng) cmd.load = 1'b1;
        else        status_d = STAT_RANGE;
      end
      OP_INSERT: begin
        // Range check comes before the full check.
        if (idx_x > fill_x) begin
          status_d = STAT_RANGE;
        end else if (full) begin
          status_d = STAT_FULL;
        end else begin
          cmd.load     = 1'b1;
          cmd.shift_up = 1'b1;
          fill_d       = fill_q + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (in_rng) begin
          cmd.shift_down = 1'b1;
          fill_d         = fill_q - CNT_W'(1);
        end else begin
          status_d = STAT_RANGE;
        end
      end
      OP_PUSH: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          cmd.load = 1'b1;
          cmd_idx  = fill_x[AW-1:0];
          fill_d   = fill_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) status_d = STAT_EMPTY;
        else       fill_d   = fill_q - CNT_W'(1);
      end
      OP_CLEAR: begin
        fill_d = '0;
      end
      OP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_en_d   = 1'b1;
          rd_addr_d = '0;
        end
      end
      OP_BACK: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_en_d   = 1'b1;
          rd_addr_d = RA_W'(fill_m1[AW-1:0]);
        end
      end
      default: ;  // unused codes: no effect, status ok
    endcase
    cmd.en = in_accept;
  end

  // ---------------------------------------------------------------------------
  // Row of cells; padded to whole groups for the read-out tree
  // ---------------------------------------------------------------------------
  logic [ELEMENT_BITS-1:0] row [ROW_LEN];

  for (genvar i = 0; i < ROW_LEN; i++) begin : g_row
    if (i < CAPACITY) begin : g_cell
      logic [ELEMENT_BITS-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = row[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = row[i+1];
      end
      iaie_cell #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .ADDR_W       (AW),
        .CELL_IDX     (i)
      ) u_cell (
        .clk_i   (clk_i),
        .cmd_i   (cmd),
        .idx_i   (cmd_idx),
        .value_i (elem_value),
        .left_i  (left_w),
        .right_i (right_w),
        .data_o  (row[i])
      );
    end else begin : g_pad
      assign row[i] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Read-out: group select in FSM_GROUP, final select feeds the result register
  // ---------------------------------------------------------------------------
  logic [ELEMENT_BITS-1:0] rd_data;
  logic [ValueW-1:0]       rd_word;

  iaie_rdtree #(
    .ELEMENT_BITS (ELEMENT_BITS),
    .NUM_GROUPS   (NG)
  ) u_rdtree (
    .clk_i    (clk_i),
    .grp_en_i (state_q == FSM_GROUP),
    .cells_i  (row),
    .addr_i   (rd_addr_q),
    .data_o   (rd_data)
  );

  if (ELEMENT_BITS >= ValueW) begin : g_rd_trunc
    assign rd_word = rd_data[ValueW-1:0];
  end else begin : g_rd_ext
    assign rd_word = ValueW'(rd_data);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: idle -> group select -> final (wait here while the result slot is full)
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == FSM_FINAL) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:  if (in_accept) state_d = FSM_GROUP;
      FSM_GROUP: state_d = FSM_FINAL;
      FSM_FINAL: if (out_load)  state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        fill_q <= fill_d;
      end
      // Hold the word until taken; refill from the final stage.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  logic [XW-1:0] fill_d_x;
  assign fill_d_x = XW'(fill_d);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_en_q       <= rd_en_d;
      rd_addr_q     <= rd_addr_d;
      pend_status_q <= status_d;
      pend_count_q  <= fill_d_x[CountW-1:0];
    end
    if (out_load) begin
      out_value_q  <= rd_en_q ? rd_word : '0;
      out_status_q <= pend_status_q;
      out_count_q  <= pend_count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = out_value_q;
  assign status_o        = out_status_q;
  assign element_count_o = out_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(fill_q) <= XW'(CAPACITY))
    else $error("element count above capacity");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != STAT_OK) |-> (out_value_q == '0))
    else $error("failed request returned nonzero data");

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == FSM_GROUP) && !in_ready_o)
    else $error("sequencer did not advance after accept");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == STAT_EMPTY) |-> (out_count_q == '0))
    else $error("empty status with nonzero count");
`endif

endmodule
`default_nettype wire

### dv/indexed_array_insert_erase_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the indexed array insert/erase core with its own array predictor.
module indexed_array_insert_erase_core_tb;
  import iaie_pkg::*;

  localparam int unsigned Capacity   = DefCapacity;
  localparam int unsigned IndexMax   = Capacity;     // highest index a random request carries
  localparam int unsigned MaxWait    = 16;           // longest idle gap or stall per word
  localparam int unsigned MaxReports = 10;
  localparam int unsigned IdleLimit  = 2000;         // cycles without any handshake
  localparam int unsigned DrainWait  = 12;           // tail cycles after the last result
  localparam int unsigned WordTarget = 1825;         // directed plus random request words
  localparam logic [OpW-1:0] OpUnusedLo = 4'd9;
  localparam logic [OpW-1:0] OpUnusedHi = 4'd15;

  // Traffic shape of a random stretch: net growth, net shrink, or balanced.
  typedef enum logic [1:0] {
    ModeFlat,
    ModeGrow,
    ModeShrink
  } mode_e;

  // One request word, plus how long to idle before it and whether to drain first.
  typedef struct {
    logic [OpW-1:0]    op;
    logic [IndexW-1:0] idx;
    logic [ValueW-1:0] val;
    int unsigned       gap;
    bit                drain;
  } request_t;

  // One result word as the array should report it.
  typedef struct {
    logic [ValueW-1:0]  rd;
    logic [StatusW-1:0] st;
    logic [CountW-1:0]  cnt;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [OpW-1:0]     operation_i = '0;
  logic [IndexW-1:0]  index_i = '0;
  logic [ValueW-1:0]  value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ValueW-1:0]  read_value_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  element_count_o;

  indexed_array_insert_erase_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .index_i         (index_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_value_o    (read_value_o),
    .status_o        (status_o),
    .element_count_o (element_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: packed contents and the element count.
  logic [ValueW-1:0] store_cells [Capacity];
  int unsigned       store_fill = 0;

  request_t    pending_words [$];   // requests not yet driven
  outcome_t    result_queue [$];    // predicted results not yet seen
  int unsigned error_count = 0;

  // Generator bookkeeping: element count as the queued requests will leave it.
  int unsigned gen_fill  = 0;
  int unsigned gen_words = 0;
  bit          gen_calm  = 1'b0;

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  bit          word_in_taken  = 1'b0;
  bit          word_out_taken = 1'b0;

  int unsigned send_wait   = 0;
  bit          gap_loaded  = 1'b0;
  int unsigned stall_left  = 0;
  bit          stall_loaded = 1'b0;
  bit          resp_calm   = 1'b0;
  int unsigned resp_words  = 0;
  int unsigned idle_cycles = 0;

  // Apply one request to the predicted array and return the result it must produce.
  function automatic outcome_t apply_request(input logic [OpW-1:0]    op,
                                             input logic [IndexW-1:0] idx,
                                             input logic [ValueW-1:0] val);
    outcome_t res;
    res.rd = '0;
    res.st = STAT_OK;
    case (op)
      OP_READ: begin
        if (idx < store_fill) res.rd = store_cells[idx];
        else res.st = STAT_RANGE;
      end
      OP_WRITE: begin
        if (idx < store_fill) store_cells[idx] = val;
        else res.st = STAT_RANGE;
      end
      OP_INSERT: begin
        // Range check wins over the full check.
        if (idx > store_fill) begin
          res.st = STAT_RANGE;
        end else if (store_fill >= Capacity) begin
          res.st = STAT_FULL;
        end else begin
          for (int j = store_fill; j > idx; j--) store_cells[j] = store_cells[j-1];
          store_cells[idx] = val;
          store_fill++;
        end
      end
      OP_ERASE: begin
        if (idx >= store_fill) begin
          res.st = STAT_RANGE;
        end else begin
          for (int j = idx; j + 1 < store_fill; j++) store_cells[j] = store_cells[j+1];
          store_fill--;
        end
      end
      OP_PUSH: begin
        if (store_fill >= Capacity) begin
          res.st = STAT_FULL;
        end else begin
          store_cells[store_fill] = val;
          store_fill++;
        end
      end
      OP_POP: begin
        if (store_fill == 0) res.st = STAT_EMPTY;
        else store_fill--;
      end
      OP_CLEAR: store_fill = 0;
      OP_FRONT: begin
        if (store_fill == 0) res.st = STAT_EMPTY;
        else res.rd = store_cells[0];
      end
      OP_BACK: begin
        if (store_fill == 0) res.st = STAT_EMPTY;
        else res.rd = store_cells[store_fill-1];
      end
      default: ;  // unused codes: no effect, status ok
    endcase
    res.cnt = CountW'(store_fill);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Queue one request word; track the count it leaves so later indices aim well.
  task automatic queue_word(input logic [OpW-1:0]    op,
                            input logic [IndexW-1:0] idx,
                            input logic [ValueW-1:0] val,
                            input bit                drain);
    request_t w;
    // Every 64 words, draw anew whether to use busy gaps or a back-to-back stretch.
    if (gen_words % 64 == 0) gen_calm = ($urandom_range(0, 3) == 0);
    w.op    = op;
    w.idx   = idx;
    w.val   = val;
    w.gap   = gen_calm ? 0 : $urandom_range(0, MaxWait);
    w.drain = drain;
    pending_words.insert(pending_words.size(), w);
    gen_words++;
    case (op)
      OP_INSERT: if (idx <= gen_fill && gen_fill < Capacity) gen_fill++;
      OP_ERASE:  if (idx < gen_fill) gen_fill--;
      OP_PUSH:   if (gen_fill < Capacity) gen_fill++;
      OP_POP:    if (gen_fill > 0) gen_fill--;
      OP_CLEAR:  gen_fill = 0;
      default: ;
    endcase
  endtask

  function automatic logic [OpW-1:0] pick_op(input mode_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r == 0) return OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
    case (mode)
      ModeGrow: begin
        if (r < 40) return OP_PUSH;
        if (r < 70) return OP_INSERT;
        if (r < 80) return OP_READ;
        if (r < 88) return OP_WRITE;
        if (r < 92) return OP_ERASE;
        if (r < 95) return OP_POP;
        if (r < 97) return OP_FRONT;
        return OP_BACK;
      end
      ModeShrink: begin
        if (r < 40) return OP_ERASE;
        if (r < 70) return OP_POP;
        if (r < 78) return OP_READ;
        if (r < 84) return OP_WRITE;
        if (r < 88) return OP_INSERT;
        if (r < 92) return OP_PUSH;
        if (r < 96) return OP_FRONT;
        return OP_BACK;
      end
      default: begin
        if (r < 14) return OP_READ;
        if (r < 26) return OP_WRITE;
        if (r < 40) return OP_INSERT;
        if (r < 54) return OP_ERASE;
        if (r < 68) return OP_PUSH;
        if (r < 80) return OP_POP;
        if (r < 89) return OP_FRONT;
        if (r < 98) return OP_BACK;
        return OP_CLEAR;
      end
    endcase
  endfunction

  // Mostly in range, biased to the ends; now and then anywhere up to IndexMax.
  function automatic logic [IndexW-1:0] pick_index(input logic [OpW-1:0] op,
                                                   input int unsigned    fill);
    int unsigned top;
    if ($urandom_range(0, 9) == 0) return IndexW'($urandom_range(0, IndexMax));
    if (op != OP_INSERT && fill == 0) return IndexW'($urandom_range(0, 3));
    top = (op == OP_INSERT) ? fill : fill - 1;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return IndexW'(top);
      default: return IndexW'($urandom_range(0, top));
    endcase
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word(input mode_e mode, input bit drain);
    logic [OpW-1:0] op;
    op = pick_op(mode);
    queue_word(op, pick_index(op, gen_fill), pick_value(), drain);
  endtask

  // Request driver: hold a word until taken, idle its gap, drain on request.
  always @(negedge clk_i) begin
    request_t w;
    logic     next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_in_taken) begin
      // hold the word until the core takes it
    end else begin
      next_valid = 1'b0;
      if (pending_words.size() != 0) begin
        if (!gap_loaded) begin
          send_wait  = pending_words[0].gap;
          gap_loaded = 1'b1;
        end
        if (send_wait > 0) begin
          send_wait--;
        end else if (!(pending_words[0].drain && result_queue.size() != 0)) begin
          w = pending_words.pop_front();
          operation_i <= w.op;
          index_i     <= w.idx;
          value_i     <= w.val;
          next_valid  = 1'b1;
          gap_loaded  = 1'b0;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Result receiver: draw a stall after each taken word, calm stretches now and then.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (word_out_taken || !stall_loaded) begin
        if (word_out_taken) begin
          resp_words++;
          if (resp_words % 48 == 0) resp_calm = ($urandom_range(0, 3) == 0);
        end
        stall_left   = resp_calm ? 0 : $urandom_range(0, MaxWait);
        stall_loaded = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on every taken request, check every taken result in order.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      word_in_taken  <= in_valid_i && in_ready_o;
      word_out_taken <= out_valid_o && out_ready_i;
      // Predict first so a same-edge result still finds its entry.
      if (in_valid_i && in_ready_o)
        result_queue.insert(result_queue.size(),
                            apply_request(operation_i, index_i, value_i));
      if (out_valid_o && out_ready_i) begin
        if (result_queue.size() == 0) begin
          flag_error($sformatf("result word with none pending: value %08h status %0d count %0d",
                               read_value_o, status_o, element_count_o));
        end else begin
          want = result_queue.pop_front();
          if (read_value_o !== want.rd || status_o !== want.st ||
              element_count_o !== want.cnt)
            flag_error($sformatf({"result mismatch: value %08h/%08h status %0d/%0d ",
                                  "count %0d/%0d (got/exp)"},
                                 read_value_o, want.rd, status_o, want.st,
                                 element_count_o, want.cnt));
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("indexed_array_insert_erase_core verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;

    // Directed: empty-array failures, unused codes, edges of a small array.
    queue_word(OP_POP,     '0, '0, 1'b0);
    queue_word(OP_FRONT,   '0, '0, 1'b0);
    queue_word(OP_BACK,    '0, '0, 1'b0);
    queue_word(OP_READ,    '0, '0, 1'b0);
    queue_word(OP_WRITE,   '0, '1, 1'b0);
    queue_word(OP_ERASE,   '0, '0, 1'b0);
    queue_word(OP_INSERT,  IndexW'(1), '1, 1'b0);
    queue_word(OP_INSERT,  IndexW'(IndexMax), '1, 1'b0);
    queue_word(OP_CLEAR,   '0, '0, 1'b0);
    queue_word(OpUnusedLo, IndexW'(IndexMax), '1, 1'b0);
    queue_word(OpUnusedHi, '1, '0, 1'b0);
    queue_word(OP_INSERT,  '0, '1, 1'b0);
    queue_word(OP_PUSH,    '0, '0, 1'b0);
    queue_word(OP_INSERT,  IndexW'(1), 32'h5A5A_A5A5, 1'b0);  // lands in the middle
    queue_word(OP_READ,    '0, '0, 1'b0);
    queue_word(OP_READ,    IndexW'(2), '0, 1'b0);
    queue_word(OP_READ,    IndexW'(3), '0, 1'b0);
    queue_word(OP_WRITE,   IndexW'(2), 32'h8000_0001, 1'b0);
    queue_word(OP_WRITE,   IndexW'(3), '1, 1'b0);
    queue_word(OP_FRONT,   '0, '0, 1'b0);
    queue_word(OP_BACK,    '0, '0, 1'b0);
    queue_word(OP_ERASE,   IndexW'(1), '0, 1'b0);
    queue_word(OP_ERASE,   IndexW'(2), '0, 1'b0);
    queue_word(OP_POP,     '0, '0, 1'b0);
    queue_word(OP_CLEAR,   '0, '0, 1'b0);

    // Random: balanced traffic, then fill to capacity and sit there,
    // then drain to empty, then balanced again up to the word target.
    repeat (500) random_word(ModeFlat, 1'b0);
    random_word(ModeGrow, 1'b1);  // wait for every pending result first
    for (int n = 0; n < 1200 && gen_fill < Capacity; n++) random_word(ModeGrow, 1'b0);
    repeat (40) random_word(ModeGrow, 1'b0);
    for (int n = 0; n < 1200 && gen_fill > 0; n++) random_word(ModeShrink, 1'b0);
    repeat (20) random_word(ModeShrink, 1'b0);
    while (gen_words < WordTarget) random_word(ModeFlat, 1'b0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait out every request and result, then let the pipeline settle.
    while (pending_words.size() != 0 || in_valid_i || result_queue.size() != 0)
      @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (error_count == 0) begin
      $display("indexed_array_insert_erase_core verification clean");
    end else begin
      $display("indexed_array_insert_erase_core verification failed");
    end
    $finish;
  end

endmodule
